@@ design/clcd_pkg.sv @@
// Shared types and constants for the character LCD 4-bit write sequencer.
package clcd_pkg;

    localparam int FUNC_W       = 2;
    localparam int BYTE_W       = 8;
    localparam int NUM_W        = 14;
    localparam int COUNT_W      = 3;
    localparam int NIB_W        = 4;
    localparam int HOLD_W       = 16;
    localparam int PHASE_HOLD_W = 10;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam int BCD_DIGITS   = 5;
    localparam int DIGIT_IDX_W  = $clog2(BCD_DIGITS);
    localparam int CONV_CNT_W   = $clog2(NUM_W + 1);

    localparam int STEP_W       = 5;
    localparam int QDEPTH       = 2;
    localparam int QPTR_W       = $clog2(QDEPTH);

    localparam logic [FUNC_W-1:0] FUNC_CMD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DATA   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_NUMBER = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_POWER  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_HOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_WAIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAKE_WAIT  = 2'd2;

    localparam logic [PHASE_HOLD_W-1:0] PHASE_HOLD_RST = 10'd100;
    localparam logic [HOLD_W-1:0]       POWER_WAIT_RST = 16'd50000;
    localparam logic [HOLD_W-1:0]       WAKE_WAIT_RST  = 16'd5000;

    localparam logic [STEP_W-1:0] BYTE_PHASES     = 5'd4;
    localparam logic [STEP_W-1:0] POWER_PHASES    = 5'd23;
    localparam logic [STEP_W-1:0] POWER_IDLE_STEP = 5'd0;
    localparam logic [STEP_W-1:0] WAKE_HIGH_STEP  = 5'd1;
    localparam logic [STEP_W-1:0] WAKE_LOW_STEP   = 5'd2;
    localparam logic [STEP_W-1:0] POWER_CMD_BASE  = 5'd3;
    localparam logic [STEP_W-1:0] CLEAR_LAST_STEP = 5'd11;

    localparam logic [HOLD_W-1:0] CLEAR_EXTRA_US = 16'd100;
    localparam logic [NIB_W-1:0]  WAKE_NIBBLE    = 4'h2;
    localparam logic [NIB_W-1:0]  ASCII_ZERO_HI  = 4'h3;

    typedef struct packed {
        logic [FUNC_W-1:0]                 func;
        logic [BYTE_W-1:0]                 byte_val;
        logic [BCD_DIGITS-1:0][NIB_W-1:0]  digits;
        logic [COUNT_W-1:0]                count;
    } entry_t;

    function automatic logic [BYTE_W-1:0] init_cmd(input logic [2:0] idx);
        logic [BYTE_W-1:0] b;
        case (idx)
            3'd0:    b = 8'h28;
            3'd1:    b = 8'h08;
            3'd2:    b = 8'h01;
            3'd3:    b = 8'h06;
            3'd4:    b = 8'h0C;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ design/clcd_front.sv @@
// Front end: accepts requests, drops number requests with a bad digit count and converts numbers to BCD.
module clcd_front #(
    parameter int MAX_DIGITS = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [clcd_pkg::FUNC_W-1:0]   func,
    input  logic [clcd_pkg::BYTE_W-1:0]   byte_value,
    input  logic [clcd_pkg::NUM_W-1:0]    number_value,
    input  logic [clcd_pkg::COUNT_W-1:0]  digit_count,
    output logic                          push,
    output clcd_pkg::entry_t              push_entry,
    input  logic                          q_full
);

    localparam int LIMIT_W = 18;
    localparam logic [LIMIT_W-1:0] NUM_LIMIT = LIMIT_W'(10 ** MAX_DIGITS - 1);

    logic                                  hold_valid_reg, hold_valid_next;
    logic [clcd_pkg::CONV_CNT_W-1:0]       conv_cnt_reg, conv_cnt_next;
    logic [clcd_pkg::NUM_W-1:0]            bin_reg, bin_next;
    clcd_pkg::entry_t                      entry_reg, entry_next;

    logic                                  accept;
    logic                                  bad_count;
    logic [LIMIT_W-1:0]                    num_ext;
    logic [clcd_pkg::NUM_W-1:0]            num_sat;
    logic [clcd_pkg::BCD_DIGITS-1:0][clcd_pkg::NIB_W-1:0] adj;
    logic [clcd_pkg::BCD_DIGITS*clcd_pkg::NIB_W:0]        shifted;

    assign push   = hold_valid_reg && (conv_cnt_reg == '0) && !q_full;
    assign busy   = hold_valid_reg && !push;
    assign accept = start && !busy;
    assign push_entry = entry_reg;

    assign bad_count = (digit_count == '0) || (digit_count > clcd_pkg::COUNT_W'(MAX_DIGITS));
    assign num_ext   = LIMIT_W'(number_value);
    assign num_sat   = (num_ext > NUM_LIMIT) ? clcd_pkg::NUM_W'(NUM_LIMIT) : number_value;

    always_comb
    begin
        for (int i = 0; i < clcd_pkg::BCD_DIGITS; i++)
        begin
            adj[i] = (entry_reg.digits[i] >= 4'd5) ? entry_reg.digits[i] + 4'd3
                                                   : entry_reg.digits[i];
        end
    end

    assign shifted = {adj, bin_reg[clcd_pkg::NUM_W-1]};

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        conv_cnt_next   = conv_cnt_reg;
        bin_next        = bin_reg;
        entry_next      = entry_reg;
        if (push)
        begin
            hold_valid_next = 1'b0;
        end
        if (hold_valid_reg && (conv_cnt_reg != '0))
        begin
            entry_next.digits = shifted[clcd_pkg::BCD_DIGITS*clcd_pkg::NIB_W-1:0];
            bin_next      = {bin_reg[clcd_pkg::NUM_W-2:0], 1'b0};
            conv_cnt_next = conv_cnt_reg - 1'b1;
        end
        if (accept && !((func == clcd_pkg::FUNC_NUMBER) && bad_count))
        begin
            hold_valid_next     = 1'b1;
            entry_next.func     = func;
            entry_next.byte_val = byte_value;
            entry_next.count    = digit_count;
            entry_next.digits   = '0;
            bin_next            = num_sat;
            conv_cnt_next       = (func == clcd_pkg::FUNC_NUMBER)
                                  ? clcd_pkg::CONV_CNT_W'(clcd_pkg::NUM_W) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            conv_cnt_reg   <= '0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            conv_cnt_reg   <= conv_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg   <= bin_next;
        entry_reg <= entry_next;
    end

endmodule

@@ design/clcd_queue.sv @@
// Two-entry request queue between the front end and the phase sequencer.
module clcd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  clcd_pkg::entry_t  push_entry,
    output logic              full,
    input  logic              pop,
    output logic              empty,
    output clcd_pkg::entry_t  head
);

    localparam int CNT_W = $clog2(clcd_pkg::QDEPTH + 1);

    clcd_pkg::entry_t                mem_reg [clcd_pkg::QDEPTH];
    logic [clcd_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [clcd_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;

    assign full  = (cnt_reg == CNT_W'(clcd_pkg::QDEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ design/clcd_back.sv @@
// Phase sequencer: expands queued requests into one pin phase per cycle.
module clcd_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_empty,
    input  clcd_pkg::entry_t                  head,
    output logic                              pop,
    input  logic [clcd_pkg::PHASE_HOLD_W-1:0] phase_hold,
    input  logic [clcd_pkg::HOLD_W-1:0]       power_wait,
    input  logic [clcd_pkg::HOLD_W-1:0]       wake_wait,
    output logic                              strobe,
    output logic                              reg_select,
    output logic                              enable_line,
    output logic [clcd_pkg::NIB_W-1:0]        bus_nibble,
    output logic [clcd_pkg::HOLD_W-1:0]       hold_us,
    output logic                              last
);

    logic                             active_reg, active_next;
    logic [clcd_pkg::STEP_W-1:0]      step_reg, step_next;
    clcd_pkg::entry_t                 cur_reg, cur_next;

    logic [clcd_pkg::STEP_W-1:0]      total;
    logic [clcd_pkg::STEP_W-1:0]      sub;
    logic [clcd_pkg::DIGIT_IDX_W-1:0] digit_idx;
    logic [clcd_pkg::BYTE_W-1:0]      cur_byte;
    logic [clcd_pkg::NIB_W-1:0]       nib;
    logic [clcd_pkg::HOLD_W-1:0]      byte_hold;
    logic                             is_power;

    assign is_power = (cur_reg.func == clcd_pkg::FUNC_POWER);
    assign sub      = is_power ? step_reg - clcd_pkg::POWER_CMD_BASE : step_reg;
    assign digit_idx = clcd_pkg::DIGIT_IDX_W'(cur_reg.count - 1'b1 - sub[4:2]);

    always_comb
    begin
        case (cur_reg.func)
            clcd_pkg::FUNC_CMD,
            clcd_pkg::FUNC_DATA:   total = clcd_pkg::BYTE_PHASES;
            clcd_pkg::FUNC_NUMBER: total = {cur_reg.count, 2'b00};
            default:               total = clcd_pkg::POWER_PHASES;
        endcase
    end

    always_comb
    begin
        case (cur_reg.func)
            clcd_pkg::FUNC_CMD,
            clcd_pkg::FUNC_DATA:   cur_byte = cur_reg.byte_val;
            clcd_pkg::FUNC_NUMBER: cur_byte = {clcd_pkg::ASCII_ZERO_HI,
                                               cur_reg.digits[digit_idx]};
            default:               cur_byte = clcd_pkg::init_cmd(sub[4:2]);
        endcase
    end

    assign nib       = sub[1] ? cur_byte[3:0] : cur_byte[7:4];
    assign byte_hold = clcd_pkg::HOLD_W'(phase_hold);

    always_comb
    begin
        reg_select  = (cur_reg.func == clcd_pkg::FUNC_DATA)
                      || (cur_reg.func == clcd_pkg::FUNC_NUMBER);
        enable_line = !sub[0];
        bus_nibble  = nib;
        hold_us     = byte_hold;
        if (is_power)
        begin
            case (step_reg)
                clcd_pkg::POWER_IDLE_STEP:
                begin
                    enable_line = 1'b0;
                    bus_nibble  = '0;
                    hold_us     = power_wait;
                end
                clcd_pkg::WAKE_HIGH_STEP:
                begin
                    enable_line = 1'b1;
                    bus_nibble  = clcd_pkg::WAKE_NIBBLE;
                    hold_us     = '0;
                end
                clcd_pkg::WAKE_LOW_STEP:
                begin
                    enable_line = 1'b0;
                    bus_nibble  = clcd_pkg::WAKE_NIBBLE;
                    hold_us     = wake_wait;
                end
                default:
                begin
                    if (sub == clcd_pkg::CLEAR_LAST_STEP)
                    begin
                        hold_us = byte_hold + clcd_pkg::CLEAR_EXTRA_US;
                    end
                end
            endcase
        end
    end

    assign strobe = active_reg;
    assign last   = active_reg && (step_reg == total - 1'b1);
    assign pop    = !q_empty && (!active_reg || last);

    always_comb
    begin
        active_next = active_reg;
        step_next   = step_reg;
        cur_next    = cur_reg;
        if (pop)
        begin
            active_next = 1'b1;
            step_next   = '0;
            cur_next    = head;
        end
        else if (last)
        begin
            active_next = 1'b0;
        end
        else if (active_reg)
        begin
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            step_reg   <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

endmodule

@@ design/char_lcd_nibble_write_sequencer_core.sv @@
// Top level of the character LCD 4-bit write sequencer.
// Throughput: one pin phase per cycle, as set by the phase sequencer; numbers also pass
// through the front-end BCD converter first.
// Reset: queue empty, sequencer idle, registers at 100 / 50000 / 5000 us.
// Results cannot be stalled; busy rises only when the front end cannot hand off its request.
module char_lcd_nibble_write_sequencer_core #(
    parameter int MAX_DIGITS = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [clcd_pkg::FUNC_W-1:0]         func,
    input  logic [clcd_pkg::BYTE_W-1:0]         byte_value,
    input  logic [clcd_pkg::NUM_W-1:0]          number_value,
    input  logic [clcd_pkg::COUNT_W-1:0]        digit_count,
    input  logic                                cfg_write,
    input  logic [clcd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [clcd_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                strobe,
    output logic                                reg_select,
    output logic                                enable_line,
    output logic [clcd_pkg::NIB_W-1:0]          bus_nibble,
    output logic [clcd_pkg::HOLD_W-1:0]         hold_us,
    output logic                                last
);

    logic [clcd_pkg::PHASE_HOLD_W-1:0] phase_hold_reg, phase_hold_next;
    logic [clcd_pkg::HOLD_W-1:0]       power_wait_reg, power_wait_next;
    logic [clcd_pkg::HOLD_W-1:0]       wake_wait_reg, wake_wait_next;

    logic              q_push, q_full, q_pop, q_empty;
    clcd_pkg::entry_t  q_in, q_head;

    always_comb
    begin
        phase_hold_next = phase_hold_reg;
        power_wait_next = power_wait_reg;
        wake_wait_next  = wake_wait_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                clcd_pkg::CFG_PHASE_HOLD:
                    phase_hold_next = cfg_data[clcd_pkg::PHASE_HOLD_W-1:0];
                clcd_pkg::CFG_POWER_WAIT: power_wait_next = cfg_data;
                clcd_pkg::CFG_WAKE_WAIT:  wake_wait_next  = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_hold_reg <= clcd_pkg::PHASE_HOLD_RST;
            power_wait_reg <= clcd_pkg::POWER_WAIT_RST;
            wake_wait_reg  <= clcd_pkg::WAKE_WAIT_RST;
        end
        else
        begin
            phase_hold_reg <= phase_hold_next;
            power_wait_reg <= power_wait_next;
            wake_wait_reg  <= wake_wait_next;
        end
    end

    clcd_front #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .byte_value   (byte_value),
        .number_value (number_value),
        .digit_count  (digit_count),
        .push         (q_push),
        .push_entry   (q_in),
        .q_full       (q_full)
    );

    clcd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head       (q_head)
    );

    clcd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .head        (q_head),
        .pop         (q_pop),
        .phase_hold  (phase_hold_reg),
        .power_wait  (power_wait_reg),
        .wake_wait   (wake_wait_reg),
        .strobe      (strobe),
        .reg_select  (reg_select),
        .enable_line (enable_line),
        .bus_nibble  (bus_nibble),
        .hold_us     (hold_us),
        .last        (last)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue read while empty");

    a_enable_fall: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && enable_line |=> strobe && !enable_line
                                  && $stable(bus_nibble) && $stable(reg_select))
        else $error("enable pulse not followed by its low phase");

    a_enable_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && enable_line |-> !last)
        else $error("transaction ended with enable high");

endmodule
